### src/pts_pkg.sv
// Shared constants and types for the periodic task tick scheduler.
package pts_pkg;

  // Table size and countdown width
  localparam int NUM_SLOTS   = 8;
  localparam int COUNT_BITS  = 32;
  localparam int MAX_RESULTS = 8;

  // Fixed field widths of the request and result items
  localparam int KIND_W = 3;
  localparam int SLOT_W = 3;
  localparam int VAL_W  = 32;

  // Derived widths
  localparam int IDX_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int RES_BITS = $clog2(MAX_RESULTS + 1);

  // Largest countdown value, expressed at request-field width
  localparam logic [VAL_W-1:0] COUNT_MAX = VAL_W'((64'd1 << COUNT_BITS) - 64'd1);

  typedef logic [KIND_W-1:0]     kind_t;
  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // Operation codes
  localparam kind_t OP_TICK    = 3'd0;
  localparam kind_t OP_CREATE  = 3'd1;
  localparam kind_t OP_SUSPEND = 3'd2;
  localparam kind_t OP_RESUME  = 3'd3;
  localparam kind_t OP_DELETE  = 3'd4;

endpackage

### src/pts_if.sv
// Request and result channel interfaces of the task tick scheduler.
interface pts_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [pts_pkg::KIND_W-1:0]             kind;
  logic [pts_pkg::SLOT_W-1:0]             slot;
  logic [pts_pkg::VAL_W-1:0]              period;
  logic [pts_pkg::VAL_W-1:0]              first_delay;

  modport source (output valid, kind, slot, period, first_delay, input ready);
  modport sink   (input valid, kind, slot, period, first_delay, output ready);
endinterface

interface pts_res_if;
  logic                       valid;
  logic                       ready;
  logic [pts_pkg::SLOT_W-1:0] fired_slot;
  logic                       last;

  modport source (output valid, fired_slot, last, input ready);
  modport sink   (input valid, fired_slot, last, output ready);
endinterface

### src/periodic_task_tick_scheduler_unit.sv
// Top level of the periodic task tick scheduler: slot table, tick walker, result register.
//
//   Channel   Dir   Handshake      Payload
//   req_i     in    valid/ready    kind, slot, period, first_delay
//   res_o     out   valid/ready    fired_slot, last
//
// Create, suspend, resume, delete and unknown kinds are applied at acceptance and leave the unit idle.
// A tick is accepted in the idle state, then one shared decrement unit visits one slot per cycle
// unless the walk stalls on res_o, then the flush state releases any held result with its last marker,
// also waiting on res_o.
// A slot that fires while a result is still held and res_o is full stalls the walk.
// Reset clears the valid and running marks and the control state at once.
module periodic_task_tick_scheduler_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  pts_req_if.sink         req_i,
  pts_res_if.source       res_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  // Slot table
  logic [pts_pkg::NUM_SLOTS-1:0] slot_valid_q, slot_valid_d;
  logic [pts_pkg::NUM_SLOTS-1:0] slot_running_q, slot_running_d;
  pts_pkg::count_t               period_q [pts_pkg::NUM_SLOTS];
  pts_pkg::count_t               cnt_q    [pts_pkg::NUM_SLOTS];

  // Sequencer
  logic [1:0]                   state_q, state_d;
  logic [pts_pkg::IDX_BITS-1:0] idx_q, idx_d;
  logic [pts_pkg::RES_BITS-1:0] nres_q, nres_d;
  logic                         pend_vld_q, pend_vld_d;
  pts_pkg::slot_t               pend_slot_q, pend_slot_d;

  // Result register
  logic                         out_vld_q, out_vld_d;
  pts_pkg::slot_t               out_slot_q, out_slot_d;
  logic                         out_last_q, out_last_d;

  logic                         req_acc;
  logic                         slot_ok;
  logic [pts_pkg::IDX_BITS-1:0] req_idx;
  logic                         cre_we;
  logic [pts_pkg::VAL_W-1:0]    per_clamp, dly_clamp;
  pts_pkg::count_t              per_val, dly_val;

  logic                         active, at_zero, fire, emit_new, out_free;
  logic                         walk_go, walk_we, walk_end;
  pts_pkg::count_t              dec_opnd, dec_res;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;

  // Decode request slot and create operands
  assign slot_ok   = (int'(req_i.slot) < pts_pkg::NUM_SLOTS);
  assign req_idx   = pts_pkg::IDX_BITS'(req_i.slot);
  assign cre_we    = req_acc && slot_ok && (req_i.kind == pts_pkg::OP_CREATE) &&
                     !slot_valid_q[req_idx];
  assign per_clamp = (req_i.period > pts_pkg::COUNT_MAX) ? pts_pkg::COUNT_MAX : req_i.period;
  assign dly_clamp = (req_i.first_delay > pts_pkg::COUNT_MAX) ? pts_pkg::COUNT_MAX :
                     req_i.first_delay;
  assign per_val   = (per_clamp == '0) ? pts_pkg::count_t'(1) :
                     pts_pkg::count_t'(per_clamp);
  assign dly_val   = pts_pkg::count_t'(dly_clamp);

  // Shared decrement unit: reload on zero, else count down
  assign active   = slot_valid_q[idx_q] && slot_running_q[idx_q];
  assign at_zero  = (cnt_q[idx_q] == '0);
  assign fire     = active && at_zero;
  assign dec_opnd = at_zero ? period_q[idx_q] : cnt_q[idx_q];
  assign dec_res  = dec_opnd - pts_pkg::count_t'(1);

  assign emit_new = fire && (nres_q < pts_pkg::RES_BITS'(pts_pkg::MAX_RESULTS));
  assign out_free = !out_vld_q || res_o.ready;
  assign walk_go  = (state_q == ST_WALK) && !(emit_new && pend_vld_q && !out_free);
  assign walk_we  = walk_go && active;
  assign walk_end = (idx_q == pts_pkg::IDX_BITS'(pts_pkg::NUM_SLOTS - 1));

  // Next-state logic
  always_comb begin
    state_d        = state_q;
    idx_d          = idx_q;
    nres_d         = nres_q;
    pend_vld_d     = pend_vld_q;
    pend_slot_d    = pend_slot_q;
    slot_valid_d   = slot_valid_q;
    slot_running_d = slot_running_q;
    out_vld_d      = out_vld_q && !res_o.ready;
    out_slot_d     = out_slot_q;
    out_last_d     = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          if (req_i.kind == pts_pkg::OP_TICK) begin
            state_d    = ST_WALK;
            idx_d      = '0;
            nres_d     = '0;
            pend_vld_d = 1'b0;
          end else if (slot_ok) begin
            case (req_i.kind)
              pts_pkg::OP_CREATE: begin
                if (!slot_valid_q[req_idx]) begin
                  slot_valid_d[req_idx]   = 1'b1;
                  slot_running_d[req_idx] = 1'b1;
                end
              end
              pts_pkg::OP_SUSPEND: slot_running_d[req_idx] = 1'b0;
              pts_pkg::OP_RESUME:  slot_running_d[req_idx] = 1'b1;
              pts_pkg::OP_DELETE:  slot_valid_d[req_idx]   = 1'b0;
              default: ;
            endcase
          end
        end
      end
      ST_WALK: begin
        if (walk_go) begin
          // Push the held result out, hold the new one
          if (emit_new) begin
            if (pend_vld_q) begin
              out_vld_d  = 1'b1;
              out_slot_d = pend_slot_q;
              out_last_d = 1'b0;
            end
            pend_vld_d  = 1'b1;
            pend_slot_d = pts_pkg::SLOT_W'(idx_q);
            nres_d      = nres_q + pts_pkg::RES_BITS'(1);
          end
          if (walk_end) begin
            state_d = ST_FLUSH;
          end else begin
            idx_d = idx_q + pts_pkg::IDX_BITS'(1);
          end
        end
      end
      ST_FLUSH: begin
        // Release the final result of the tick with its last marker
        if (!pend_vld_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_vld_d  = 1'b1;
          out_slot_d = pend_slot_q;
          out_last_d = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      idx_q          <= '0;
      nres_q         <= '0;
      pend_vld_q     <= 1'b0;
      out_vld_q      <= 1'b0;
      slot_valid_q   <= '0;
      slot_running_q <= '0;
    end else begin
      state_q        <= state_d;
      idx_q          <= idx_d;
      nres_q         <= nres_d;
      pend_vld_q     <= pend_vld_d;
      out_vld_q      <= out_vld_d;
      slot_valid_q   <= slot_valid_d;
      slot_running_q <= slot_running_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_slot_q <= pend_slot_d;
    out_slot_q  <= out_slot_d;
    out_last_q  <= out_last_d;
  end

  // Period and countdown table: load on create, update on walk
  always_ff @(posedge clk_i) begin
    if (cre_we) begin
      period_q[req_idx] <= per_val;
      cnt_q[req_idx]    <= dly_val;
    end else if (walk_we) begin
      cnt_q[idx_q] <= dec_res;
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.fired_slot = out_slot_q;
  assign res_o.last       = out_last_q;

endmodule

### src/pts_checker.sv
// Port-level checker for the task tick scheduler, bound to the top level.
module pts_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic [pts_pkg::KIND_W-1:0] req_kind,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic [pts_pkg::SLOT_W-1:0] res_fired_slot,
  input logic                       res_last
);

  // Hold a stalled result
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> $stable(res_fired_slot) && $stable(res_last))
    else $error("result payload changed while stalled");

  // A tick occupies the walker: no new request next cycle
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready && req_kind == pts_pkg::OP_TICK |=> !req_ready)
    else $error("request taken during tick walk");

  // Slot operations keep the request channel ready
  a_op_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready && req_kind != pts_pkg::OP_TICK |=> req_ready)
    else $error("slot operation did not complete in one cycle");

endmodule

bind periodic_task_tick_scheduler_unit pts_checker u_pts_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid      (req_i.valid),
  .req_ready      (req_i.ready),
  .req_kind       (req_i.kind),
  .res_valid      (res_o.valid),
  .res_ready      (res_o.ready),
  .res_fired_slot (res_o.fired_slot),
  .res_last       (res_o.last)
);
